>>> hw/rtl/servo_bus_status_packet_receiver_defines.svh
// assertion macros for the servo bus status packet receiver
`ifndef SERVO_BUS_STATUS_PACKET_RECEIVER_DEFINES_SVH
`define SERVO_BUS_STATUS_PACKET_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF

`define SBSPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SBSPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SBSPR_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SBSPR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/sbspr_pkg.sv
// package for the servo bus status packet receiver: types, codes, sizes
`default_nettype none

package sbspr_pkg;

  localparam int unsigned MaxParams = 32;
  localparam int unsigned AddrW     = $clog2(MaxParams);
  localparam int unsigned CntW      = $clog2(MaxParams + 1);
  localparam int unsigned IdxW      = 5;

  localparam logic [7:0] HdrByte     = 8'hFF;
  localparam logic [7:0] BcastReset  = 8'd254;
  localparam logic [7:0] LenMin      = 8'd2;
  localparam logic [7:0] LenMax      = 8'(MaxParams + 2);

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_CSUM,
    PH_EMIT_RD,
    PH_EMIT_WAIT,
    PH_EMIT_FIN
  } phase_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbspr_ram.sv
// parameter byte store: one write port, one registered read port
`default_nettype none

module sbspr_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/servo_bus_status_packet_receiver.sv
// top level: servo bus status reply parser with parameter store and result register
//
// A begin item arms the parser for one device id (or finishes at once with success
// for the broadcast id). Received-byte and timeout items are taken one per cycle
// while parsing. A failure gives one final status item. On a good checksum the
// block stops taking input and plays back the stored parameters, each one read
// from the registered read port of the parameter memory before it is sent, then
// the final status item; the output side can stall each of them. A result that
// waits on a stalled output side holds off the input until it is taken. The
// parameter memory needs no clearing after reset.
`default_nettype none

`include "servo_bus_status_packet_receiver_defines.svh"

module servo_bus_status_packet_receiver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] expected_id_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            item_kind_o,
  output logic [2:0]      status_code_o,
  output logic [7:0]      device_error_o,
  output logic [4:0]      param_index_o,
  output logic [7:0]      param_value_o,
  output logic            last_o
);

  sbspr_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                     bcast_q;
  logic [7:0]                     want_id_q, want_id_d;
  logic                           seen_q, seen_d;
  logic [7:0]                     len_q, len_d;
  logic [7:0]                     sum_q, sum_d;
  logic [7:0]                     err_q, err_d;
  logic [sbspr_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [sbspr_pkg::CntW-1:0]     idx_q, idx_d;
  logic [sbspr_pkg::CntW-1:0]     idx_inc;
  logic [sbspr_pkg::CntW-1:0]     cnt_inc;

  logic                           out_valid_q, out_valid_d;
  logic                           kind_q, kind_d;
  logic [2:0]                     code_q, code_d;
  logic [7:0]                     derr_q, derr_d;
  logic [4:0]                     pidx_q, pidx_d;
  logic [7:0]                     pval_q, pval_d;
  logic                           last_q, last_d;

  sbspr_pkg::ram_req_t            ram_req;
  logic [7:0]                     ram_rdata;

  logic                           emitting;
  logic                           out_free;
  logic                           accept;
  logic                           ld;

  assign emitting = (phase_q == sbspr_pkg::PH_EMIT_RD) ||
                    (phase_q == sbspr_pkg::PH_EMIT_WAIT) ||
                    (phase_q == sbspr_pkg::PH_EMIT_FIN);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = emitting || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_inc    = idx_q + 1'b1;
  assign cnt_inc    = cnt_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    want_id_d = want_id_q;
    seen_d    = seen_q;
    len_d     = len_q;
    sum_d     = sum_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ld        = 1'b0;
    kind_d    = 1'b1;
    code_d    = sbspr_pkg::ST_OK;
    derr_d    = 8'd0;
    pidx_d    = 5'd0;
    pval_d    = 8'd0;
    last_d    = 1'b1;
    ram_req.we    = 1'b0;
    ram_req.waddr = cnt_q[sbspr_pkg::AddrW-1:0];
    ram_req.wdata = rx_byte_i;
    ram_req.re    = 1'b0;
    ram_req.raddr = idx_q[sbspr_pkg::AddrW-1:0];

    case (phase_q)
      sbspr_pkg::PH_EMIT_RD: begin
        ram_req.re = 1'b1;
        phase_d    = sbspr_pkg::PH_EMIT_WAIT;
      end
      sbspr_pkg::PH_EMIT_WAIT: begin
        if (out_free) begin
          ld     = 1'b1;
          kind_d = 1'b0;
          derr_d = err_q;
          pidx_d = idx_q[4:0];
          pval_d = ram_rdata;
          last_d = 1'b0;
          idx_d  = idx_inc;
          phase_d = (idx_inc >= cnt_q) ? sbspr_pkg::PH_EMIT_FIN : sbspr_pkg::PH_EMIT_RD;
        end
      end
      sbspr_pkg::PH_EMIT_FIN: begin
        if (out_free) begin
          ld      = 1'b1;
          derr_d  = err_q;
          phase_d = sbspr_pkg::PH_IDLE;
        end
      end
      default: begin
        if (accept) begin
          if (cmd_i == sbspr_pkg::CMD_BEGIN) begin
            want_id_d = expected_id_i;
            seen_d    = 1'b0;
            len_d     = 8'd0;
            sum_d     = 8'd0;
            err_d     = 8'd0;
            cnt_d     = '0;
            if (expected_id_i == bcast_q) begin
              ld      = 1'b1;
              phase_d = sbspr_pkg::PH_IDLE;
            end else begin
              phase_d = sbspr_pkg::PH_HUNT1;
            end
          end else if (phase_q != sbspr_pkg::PH_IDLE && cmd_i == sbspr_pkg::CMD_TIMEOUT) begin
            ld      = 1'b1;
            code_d  = seen_q ? sbspr_pkg::ST_SHORT : sbspr_pkg::ST_TIMEOUT;
            phase_d = sbspr_pkg::PH_IDLE;
          end else if (phase_q != sbspr_pkg::PH_IDLE && cmd_i == sbspr_pkg::CMD_BYTE) begin
            seen_d = 1'b1;
            case (phase_q)
              sbspr_pkg::PH_HUNT1: begin
                if (rx_byte_i == sbspr_pkg::HdrByte) begin
                  phase_d = sbspr_pkg::PH_HUNT2;
                end
              end
              sbspr_pkg::PH_HUNT2: begin
                phase_d = (rx_byte_i == sbspr_pkg::HdrByte) ? sbspr_pkg::PH_ID
                                                            : sbspr_pkg::PH_HUNT1;
              end
              sbspr_pkg::PH_ID: begin
                if (rx_byte_i != want_id_q) begin
                  ld      = 1'b1;
                  code_d  = sbspr_pkg::ST_BAD_ID;
                  phase_d = sbspr_pkg::PH_IDLE;
                end else begin
                  sum_d   = rx_byte_i;
                  phase_d = sbspr_pkg::PH_LEN;
                end
              end
              sbspr_pkg::PH_LEN: begin
                if (rx_byte_i < sbspr_pkg::LenMin || rx_byte_i > sbspr_pkg::LenMax) begin
                  ld      = 1'b1;
                  code_d  = sbspr_pkg::ST_SHORT;
                  phase_d = sbspr_pkg::PH_IDLE;
                end else begin
                  len_d   = rx_byte_i;
                  sum_d   = sum_q + rx_byte_i;
                  phase_d = sbspr_pkg::PH_ERR;
                end
              end
              sbspr_pkg::PH_ERR: begin
                err_d   = rx_byte_i;
                sum_d   = sum_q + rx_byte_i;
                cnt_d   = '0;
                phase_d = (len_q == sbspr_pkg::LenMin) ? sbspr_pkg::PH_CSUM
                                                       : sbspr_pkg::PH_PARAM;
              end
              sbspr_pkg::PH_PARAM: begin
                ram_req.we = (cnt_q < sbspr_pkg::CntW'(sbspr_pkg::MaxParams));
                cnt_d      = cnt_inc;
                sum_d      = sum_q + rx_byte_i;
                if (8'(cnt_inc) >= len_q - sbspr_pkg::LenMin) begin
                  phase_d = sbspr_pkg::PH_CSUM;
                end
              end
              sbspr_pkg::PH_CSUM: begin
                if (rx_byte_i != ~sum_q) begin
                  ld      = 1'b1;
                  code_d  = sbspr_pkg::ST_CHECKSUM;
                  phase_d = sbspr_pkg::PH_IDLE;
                end else begin
                  idx_d   = '0;
                  phase_d = (cnt_q == '0) ? sbspr_pkg::PH_EMIT_FIN : sbspr_pkg::PH_EMIT_RD;
                end
              end
              default: begin
                phase_d = sbspr_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end
    endcase

    if (ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sbspr_pkg::PH_IDLE;
      bcast_q     <= sbspr_pkg::BcastReset;
      want_id_q   <= 8'd0;
      seen_q      <= 1'b0;
      len_q       <= 8'd0;
      sum_q       <= 8'd0;
      err_q       <= 8'd0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        bcast_q <= cfg_wdata_i;
      end
      want_id_q   <= want_id_d;
      seen_q      <= seen_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      kind_q <= kind_d;
      code_q <= code_d;
      derr_q <= derr_d;
      pidx_q <= pidx_d;
      pval_q <= pval_d;
      last_q <= last_d;
    end
  end

  sbspr_ram #(
    .Depth (sbspr_pkg::MaxParams),
    .Width (8)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = kind_q;
  assign status_code_o  = code_q;
  assign device_error_o = derr_q;
  assign param_index_o  = pidx_q;
  assign param_value_o  = pval_q;
  assign last_o         = last_q;

  `SBSPR_ASSERT_IMP(a_last_on_status, clk_i, rst_ni, out_valid_o, last_o == item_kind_o)
  `SBSPR_ASSERT_IMP(a_fail_no_derr, clk_i, rst_ni,
                    out_valid_o && status_code_o != sbspr_pkg::ST_OK, device_error_o == 8'd0)
  `SBSPR_ASSERT_IMP(a_param_in_range, clk_i, rst_ni,
                    out_valid_o && !item_kind_o, idx_q <= cnt_q)
  `SBSPR_ASSERT_NXT(a_param_then_more, clk_i, rst_ni,
                    phase_q == sbspr_pkg::PH_EMIT_WAIT && out_free, out_valid_o && !item_kind_o)

endmodule

`default_nettype wire

>>> verif/sbspr_reply_checker.sv
// reply checker: predicts the parser's output items and compares them as they leave the block
module sbspr_reply_checker
  import sbspr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  expected_id_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        item_kind_i,
  input  logic [2:0]  status_code_i,
  input  logic [7:0]  device_error_i,
  input  logic [4:0]  param_index_i,
  input  logic [7:0]  param_value_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic [2:0] code;
    logic [7:0] dev_err;
    logic [4:0] index;
    logic [7:0] value;
    logic       last;
  } reply_t;

  reply_t      reply_q[$];
  phase_e      phase;
  logic [7:0]  bcast;
  logic [7:0]  want_id;
  logic [7:0]  reply_len;
  logic [7:0]  sum_acc;
  logic [7:0]  dev_err;
  logic [5:0]  n_params;
  logic        seen_byte;
  logic [7:0]  param_mem [MaxParams];
  int unsigned fails;

  function automatic string fmt_reply(reply_t r);
    return $sformatf("kind %0d status %0d err %02h idx %0d val %02h last %0d",
                     r.kind, r.code, r.dev_err, r.index, r.value, r.last);
  endfunction

  function automatic void push_reply(logic kind, status_e code, logic [7:0] derr,
                                     logic [4:0] idx, logic [7:0] val, logic last);
    reply_t r;
    r.kind    = kind;
    r.code    = code;
    r.dev_err = derr;
    r.index   = idx;
    r.value   = val;
    r.last    = last;
    reply_q.push_back(r);
  endfunction

  function automatic void finish_fail(status_e code);
    push_reply(1'b1, code, 8'h00, 5'd0, 8'h00, 1'b1);
    phase = PH_IDLE;
  endfunction

  function automatic void parse_item(cmd_e cmd, logic [7:0] eid, logic [7:0] b);
    if (cmd == CMD_BEGIN) begin
      want_id   = eid;
      seen_byte = 1'b0;
      reply_len = 8'd0;
      sum_acc   = 8'd0;
      dev_err   = 8'd0;
      n_params  = 6'd0;
      if (eid == bcast) begin
        push_reply(1'b1, ST_OK, 8'h00, 5'd0, 8'h00, 1'b1);
        phase = PH_IDLE;
      end else begin
        phase = PH_HUNT1;
      end
    end else if (phase != PH_IDLE && cmd != CMD_NONE) begin
      if (cmd == CMD_TIMEOUT) begin
        finish_fail(seen_byte ? ST_SHORT : ST_TIMEOUT);
      end else begin
        seen_byte = 1'b1;
        case (phase)
          PH_HUNT1: begin
            if (b == HdrByte) phase = PH_HUNT2;
          end
          PH_HUNT2: begin
            phase = (b == HdrByte) ? PH_ID : PH_HUNT1;
          end
          PH_ID: begin
            if (b != want_id) begin
              finish_fail(ST_BAD_ID);
            end else begin
              sum_acc = b;
              phase   = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b < 8'd2 || (b - 8'd2) > 8'(MaxParams)) begin
              finish_fail(ST_SHORT);
            end else begin
              reply_len = b;
              sum_acc   = sum_acc + b;
              phase     = PH_ERR;
            end
          end
          PH_ERR: begin
            dev_err  = b;
            sum_acc  = sum_acc + b;
            n_params = 6'd0;
            phase    = (reply_len == 8'd2) ? PH_CSUM : PH_PARAM;
          end
          PH_PARAM: begin
            if (n_params < MaxParams) param_mem[n_params[4:0]] = b;
            n_params = n_params + 6'd1;
            sum_acc  = sum_acc + b;
            if ({2'b00, n_params} >= reply_len - 8'd2) phase = PH_CSUM;
          end
          default: begin
            if (b != ~sum_acc) begin
              finish_fail(ST_CHECKSUM);
            end else begin
              for (int i = 0; i < n_params && i < MaxParams; i++) begin
                push_reply(1'b0, ST_OK, dev_err, 5'(i), param_mem[5'(i)], 1'b0);
              end
              push_reply(1'b1, ST_OK, dev_err, 5'd0, 8'h00, 1'b1);
              phase = PH_IDLE;
            end
          end
        endcase
      end
    end
  endfunction

  function automatic void check_reply();
    reply_t got;
    reply_t want;
    got.kind    = item_kind_i;
    got.code    = status_code_i;
    got.dev_err = device_error_i;
    got.index   = param_index_i;
    got.value   = param_value_i;
    got.last    = last_i;
    if (reply_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected output item: %s", fmt_reply(got));
    end else begin
      want = reply_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("output item mismatch: expected %s, actual %s",
                   fmt_reply(want), fmt_reply(got));
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q.delete();
      bcast        = BcastReset;
      phase        = PH_IDLE;
      want_id      = 8'd0;
      reply_len    = 8'd0;
      sum_acc      = 8'd0;
      dev_err      = 8'd0;
      n_params     = 6'd0;
      seen_byte    = 1'b0;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_reply();
      if (cfg_we_i) bcast = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) parse_item(cmd_e'(cmd_i), expected_id_i, rx_byte_i);
      fail_count_o <= fails;
      pending_o    <= reply_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// testbench top: clock, reset, item and register stimulus, and the run verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbspr_pkg::*;

  typedef enum {
    FLAW_NONE,
    FLAW_BAD_ID,
    FLAW_BAD_LEN,
    FLAW_BAD_SUM,
    FLAW_CUT,
    FLAW_DROP
  } flaw_e;

  localparam int LongHold  = 300;
  localparam int DrainWait = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  cmd_i         = 2'd0;
  logic [7:0]  expected_id_i = 8'h00;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        item_kind_o;
  logic [2:0]  status_code_o;
  logic [7:0]  device_error_o;
  logic [4:0]  param_index_o;
  logic [7:0]  param_value_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int          stall_left    = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [7:0]  bcast         = BcastReset;

  servo_bus_status_packet_receiver DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .expected_id_i  (expected_id_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .status_code_o  (status_code_o),
    .device_error_o (device_error_o),
    .param_index_o  (param_index_o),
    .param_value_o  (param_value_o),
    .last_o         (last_o)
  );

  sbspr_reply_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .expected_id_i  (expected_id_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_i    (item_kind_o),
    .status_code_i  (status_code_o),
    .device_error_i (device_error_o),
    .param_index_i  (param_index_o),
    .param_value_i  (param_value_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (quiet) begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic offer(input cmd_e c, input logic [7:0] eid, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    expected_id_i <= eid;
    rx_byte_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_bcast(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bcast = v;
  endtask

  task automatic send_reply(input logic [7:0] dev, input int n_par, input flaw_e flaw);
    logic [7:0] seq[$];
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] sum;
    int         stop;
    seq = {};
    repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 254)));
    if ($urandom_range(0, 3) == 0) begin
      seq.push_back(HdrByte);
      seq.push_back(8'($urandom_range(0, 254)));
    end
    seq.push_back(HdrByte);
    seq.push_back(HdrByte);
    len = 8'(n_par + 2);
    err = 8'($urandom_range(0, 255));
    if (flaw == FLAW_BAD_ID) seq.push_back(dev ^ 8'($urandom_range(1, 255)));
    else seq.push_back(dev);
    if (flaw == FLAW_BAD_LEN) begin
      len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(35, 255));
    end
    if (flaw != FLAW_BAD_ID) begin
      seq.push_back(len);
      if (flaw != FLAW_BAD_LEN) begin
        seq.push_back(err);
        sum = dev + len + err;
        repeat (n_par) begin
          seq.push_back(8'($urandom()));
          sum = sum + seq[$];
        end
        sum = ~sum;
        if (flaw == FLAW_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        seq.push_back(sum);
      end
    end
    stop = seq.size();
    if (flaw == FLAW_CUT || flaw == FLAW_DROP) stop = $urandom_range(0, seq.size() - 1);
    offer(CMD_BEGIN, dev, 8'($urandom()));
    for (int i = 0; i < stop; i++) offer(CMD_BYTE, 8'($urandom()), seq[i]);
    if (flaw == FLAW_CUT) offer(CMD_TIMEOUT, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic random_traffic(input int unsigned upto);
    int unsigned pick;
    logic [7:0]  dev;
    int          n;
    while (items_sent < upto) begin
      pick = $urandom_range(0, 99);
      dev  = 8'($urandom_range(0, 255));
      if (dev == bcast) dev = dev ^ 8'h01;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 32) : $urandom_range(0, 6);
      if (pick < 58) send_reply(dev, n, FLAW_NONE);
      else if (pick < 68) send_reply(dev, n, FLAW_BAD_SUM);
      else if (pick < 74) send_reply(dev, n, FLAW_BAD_ID);
      else if (pick < 80) send_reply(dev, n, FLAW_BAD_LEN);
      else if (pick < 87) send_reply(dev, n, FLAW_CUT);
      else if (pick < 90) send_reply(dev, n, FLAW_DROP);
      else if (pick < 94) offer(CMD_BEGIN, bcast, 8'($urandom()));
      else offer(cmd_e'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle inputs and unused command
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_TIMEOUT, 8'hFF, 8'h00);
    offer(CMD_NONE, 8'hFF, 8'hFF);
    // broadcast at reset value
    offer(CMD_BEGIN, 8'd254, 8'h00);
    // timeout with and without a byte seen
    offer(CMD_BEGIN, 8'h00, 8'h00);
    offer(CMD_TIMEOUT, 8'h00, 8'h00);
    offer(CMD_BEGIN, 8'h00, 8'h00);
    offer(CMD_BYTE, 8'h00, 8'h00);
    offer(CMD_TIMEOUT, 8'h00, 8'h00);
    // broken header, id ff, no parameters
    offer(CMD_BEGIN, 8'hFF, 8'h00);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'h00);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'h02);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    // wrong id
    offer(CMD_BEGIN, 8'h01, 8'h00);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'h02);
    // begin while busy, then length too small
    offer(CMD_BEGIN, 8'h01, 8'h00);
    offer(CMD_NONE, 8'h00, 8'h00);
    offer(CMD_BEGIN, 8'h03, 8'h00);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'hFF);
    offer(CMD_BYTE, 8'h00, 8'h03);
    offer(CMD_BYTE, 8'h00, 8'h00);
    drain();

    send_reply(8'h5A, 32, FLAW_NONE);
    random_traffic(80);
    drain();
    write_bcast(8'h00);
    random_traffic(110);

    // long output hold while items keep coming
    long_hold_req = 1'b1;
    repeat (6) offer(CMD_BEGIN, bcast, 8'($urandom()));
    send_reply(8'h33, 12, FLAW_NONE);
    random_traffic(145);
    drain();
    write_bcast(8'hFF);
    random_traffic(180);
    drain();
    write_bcast(8'($urandom()));
    quiet = 1'b1;
    random_traffic(215);
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sbspr_pkg.sv
hw/rtl/sbspr_ram.sv
hw/rtl/servo_bus_status_packet_receiver.sv
verif/sbspr_reply_checker.sv
verif/tb_top.sv
